// File: rtl/assert_macros.svh
// Assertion macros shared by the grid snap and ratio constraint RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GSRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/gsrc_pkg.sv
// Types, constants and helper functions for the grid snap and ratio constraint block.
`default_nettype none
package gsrc_pkg;

    localparam int C_FRAC_BITS = 8;
    localparam int C_FW        = 24;  // coordinate field width
    localparam int C_VW        = 32;  // snapped coordinate / difference magnitude width
    localparam int C_RW        = 34;  // result width before saturation
    localparam int C_STEP_W    = 13;
    localparam int C_RAT_W     = 8;
    localparam int C_COEF_W    = 12;
    localparam int C_IDX_W     = 3;
    localparam int C_CFG_W     = 13;

    localparam logic [C_STEP_W-1:0] C_STEP_RST = 13'd64;
    localparam logic [C_RAT_W-1:0]  C_LOW_RST  = 8'd1;
    localparam logic [C_RAT_W-1:0]  C_HIGH_RST = 8'd3;

    typedef enum logic [C_IDX_W-1:0] {
        CFG_SNAP_EN    = 3'd0,
        CFG_GRID_STEP  = 3'd1,
        CFG_RATIO_MODE = 3'd2,
        CFG_RATIO_LOW  = 3'd3,
        CFG_RATIO_HIGH = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_FREE = 3'd0,
        MODE_1_1  = 3'd1,
        MODE_2_1  = 3'd2,
        MODE_4_1  = 3'd3,
        MODE_8_1  = 3'd4,
        MODE_5_4  = 3'd5,
        MODE_7_4  = 3'd6,
        MODE_USER = 3'd7
    } t_mode;

    // Axis lock threshold of the fixed ratio modes.
    function automatic logic [C_COEF_W-1:0] f_thr(input t_mode m);
        logic [C_COEF_W-1:0] r;
        unique case (m)
            MODE_1_1: r = 12'd2;
            MODE_2_1: r = 12'd4;
            MODE_4_1: r = 12'd8;
            MODE_8_1: r = 12'd16;
            MODE_5_4: r = 12'd3;
            MODE_7_4: r = 12'd3;
            default:  r = 12'd1;
        endcase
        return r;
    endfunction

    function automatic logic [C_RAT_W-1:0] f_num(input t_mode m);
        logic [C_RAT_W-1:0] r;
        unique case (m)
            MODE_5_4, MODE_7_4: r = 8'd4;
            default:            r = 8'd1;
        endcase
        return r;
    endfunction

    function automatic logic [C_RAT_W-1:0] f_den(input t_mode m);
        logic [C_RAT_W-1:0] r;
        unique case (m)
            MODE_2_1: r = 8'd2;
            MODE_4_1: r = 8'd4;
            MODE_8_1: r = 8'd8;
            MODE_5_4: r = 8'd5;
            MODE_7_4: r = 8'd7;
            default:  r = 8'd1;
        endcase
        return r;
    endfunction

    // Clamp a wide signed result to the coordinate range.
    function automatic logic signed [C_FW-1:0] f_sat(input logic signed [C_RW-1:0] v);
        logic signed [C_FW-1:0] r;
        if ((&v[C_RW-1:C_FW-1]) || !(|v[C_RW-1:C_FW-1])) begin
            r = v[C_FW-1:0];
        end else if (v[C_RW-1]) begin
            r = {1'b1, {(C_FW-1){1'b0}}};
        end else begin
            r = {1'b0, {(C_FW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gsrc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module gsrc_div #(
    parameter int NW = 17,
    parameter int QW = 17,
    parameter int DW = 13,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);

    // Upper DW bits hold the partial remainder, lower QW bits the dividend
    // bits still to consume followed by the quotient bits produced so far.
    logic [DW+QW-1:0] r_x   [QW];
    logic [DW+QW-1:0] n_x   [QW];
    logic [DW+QW-1:0] w_src [QW];
    logic [DW:0]      w_t   [QW];
    logic [DW:0]      w_d   [QW];
    logic [QW-1:0]    w_qb;
    logic [PW-1:0]    r_pay [QW];
    logic [QW-1:0]    r_v;

    always_comb begin
        w_src[0] = {DW'(i_num >> QW), i_num[QW-1:0]};
        for (int k = 1; k < QW; k++) begin
            w_src[k] = r_x[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_t[k]  = w_src[k][DW+QW-1:QW-1];
            w_qb[k] = (w_t[k] >= {1'b0, i_den});
            w_d[k]  = w_t[k] - {1'b0, i_den};
            n_x[k]  = {(w_qb[k] ? w_d[k][DW-1:0] : w_t[k][DW-1:0]),
                       w_src[k][QW-2:0], w_qb[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0] <= i_pay;
            for (int k = 0; k < QW; k++) begin
                r_x[k] <= n_x[k];
            end
            for (int k = 1; k < QW; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_x[QW-1][QW-1:0];
    assign o_pay   = r_pay[QW-1];

endmodule
`default_nettype wire

// File: rtl/grid_snap_ratio_constrain.sv
// Grid snap and ratio constraint: fully pipelined, one point per cycle while the result is not stalled.
// Path from input transaction to result register: stage A, the two bit-serial grid snap
//   divider pipelines, stages B to G, the bit-serial ratio scale divider, stage H.
// Throughput: one transaction per cycle; a stalled result freezes the whole pipe.
// Reset (synchronous, active low): all valid bits clear, configuration registers take defaults.
`default_nettype none
`include "assert_macros.svh"
module grid_snap_ratio_constrain #(
    parameter int FRAC_BITS = gsrc_pkg::C_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [gsrc_pkg::C_FW-1:0]    i_point_x,
    input  wire logic signed [gsrc_pkg::C_FW-1:0]    i_point_y,
    input  wire logic signed [gsrc_pkg::C_FW-1:0]    i_anchor_x,
    input  wire logic signed [gsrc_pkg::C_FW-1:0]    i_anchor_y,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [gsrc_pkg::C_FW-1:0]         o_out_x,
    output logic signed [gsrc_pkg::C_FW-1:0]         o_out_y,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gsrc_pkg::C_IDX_W-1:0]        i_cfg_index,
    input  wire logic [gsrc_pkg::C_CFG_W-1:0]        i_cfg_data
);

    localparam int FW    = gsrc_pkg::C_FW;
    localparam int VW    = gsrc_pkg::C_VW;
    localparam int RW    = gsrc_pkg::C_RW;
    localparam int SW    = gsrc_pkg::C_STEP_W;
    localparam int AW    = gsrc_pkg::C_RAT_W;
    localparam int CW    = gsrc_pkg::C_COEF_W;
    localparam int NWIDE = ((25 > SW + FRAC_BITS) ? 25 : SW + FRAC_BITS) + 1;
    localparam int NS    = NWIDE - FRAC_BITS - 1;
    localparam int BW    = NS + SW;
    localparam int PRW   = VW + CW;
    localparam int LNW   = VW + AW;
    localparam int NUMW  = LNW + 2;
    localparam int XPW   = 3 * FW;
    localparam int SPW   = 2 * RW + FW + 3;

    // ---------------- configuration ----------------
    logic                  r_snap_en;
    logic [SW-1:0]         r_grid_step;
    gsrc_pkg::t_mode       r_ratio_mode;
    logic [AW-1:0]         r_ratio_low;
    logic [AW-1:0]         r_ratio_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_en    <= 1'b0;
            r_grid_step  <= gsrc_pkg::C_STEP_RST;
            r_ratio_mode <= gsrc_pkg::MODE_FREE;
            r_ratio_low  <= gsrc_pkg::C_LOW_RST;
            r_ratio_high <= gsrc_pkg::C_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gsrc_pkg::CFG_SNAP_EN:    r_snap_en    <= i_cfg_data[0];
                gsrc_pkg::CFG_GRID_STEP:  r_grid_step  <= i_cfg_data[SW-1:0];
                gsrc_pkg::CFG_RATIO_MODE: r_ratio_mode <= gsrc_pkg::t_mode'(i_cfg_data[2:0]);
                gsrc_pkg::CFG_RATIO_LOW:  r_ratio_low  <= i_cfg_data[AW-1:0];
                gsrc_pkg::CFG_RATIO_HIGH: r_ratio_high <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // Effective ratio, lock coefficients: user holds them static while items in flight; not enforced.
    logic [AW-1:0] w_user_n;
    logic [AW-1:0] w_user_d;
    logic [AW-1:0] w_n;
    logic [AW-1:0] w_d;
    logic [CW-1:0] w_coef_a;
    logic [CW-1:0] w_coef_b;
    logic          w_lock_en;
    logic          w_snap;

    assign w_user_n = (r_ratio_low == '0) ? AW'(1) : r_ratio_low;
    assign w_user_d = (r_ratio_high < w_user_n) ? w_user_n : r_ratio_high;
    assign w_snap   = r_snap_en && (r_grid_step != '0);

    always_comb begin
        if (r_ratio_mode == gsrc_pkg::MODE_USER) begin
            w_n       = w_user_n;
            w_d       = w_user_d;
            w_coef_a  = CW'(w_user_d) * CW'(10);
            w_coef_b  = CW'(w_user_n) * CW'(3);
            w_lock_en = (CW'(w_user_n) * CW'(10)) > CW'(w_user_d);
        end else begin
            w_n       = gsrc_pkg::f_num(r_ratio_mode);
            w_d       = gsrc_pkg::f_den(r_ratio_mode);
            w_coef_a  = gsrc_pkg::f_thr(r_ratio_mode);
            w_coef_b  = CW'(1);
            w_lock_en = (r_ratio_mode != gsrc_pkg::MODE_FREE);
        end
    end

    // Whole pipe advances unless the result register is held.
    logic w_en;
    logic r_h_valid;
    assign w_en    = !(r_h_valid && i_stall);
    assign o_stall = !w_en;

    // ---------------- stage A: input register ----------------
    logic                 r_a_valid;
    logic signed [FW-1:0] r_a_px, r_a_py, r_a_ax, r_a_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_px <= i_point_x;
            r_a_py <= i_point_y;
            r_a_ax <= i_anchor_x;
            r_a_ay <= i_anchor_y;
        end
    end

    // Snap quotient: floor((2|p| + S) / 2S), S = step << FRAC_BITS,
    // done as floor(((2|p| + S) >> (FRAC_BITS + 1)) / step).
    logic [FW-1:0]    w_magx, w_magy;
    logic [NWIDE-1:0] w_snx, w_sny;
    logic [NS-1:0]    w_dnx, w_dny;

    assign w_magx = r_a_px[FW-1] ? (~r_a_px + 1'b1) : r_a_px;
    assign w_magy = r_a_py[FW-1] ? (~r_a_py + 1'b1) : r_a_py;
    assign w_snx  = (NWIDE'(w_magx) << 1) + (NWIDE'(r_grid_step) << FRAC_BITS);
    assign w_sny  = (NWIDE'(w_magy) << 1) + (NWIDE'(r_grid_step) << FRAC_BITS);
    assign w_dnx  = w_snx[NWIDE-1:FRAC_BITS+1];
    assign w_dny  = w_sny[NWIDE-1:FRAC_BITS+1];

    logic           w_divx_valid, w_divy_valid;
    logic [NS-1:0]  w_qx, w_qy;
    logic [XPW-1:0] w_payx;
    logic [FW-1:0]  w_payy;

    gsrc_div #(.NW(NS), .QW(NS), .DW(SW), .PW(XPW)) u_snap_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_valid),
        .i_num   (w_dnx),
        .i_den   (r_grid_step),
        .i_pay   ({r_a_px, r_a_ax, r_a_ay}),
        .o_valid (w_divx_valid),
        .o_quo   (w_qx),
        .o_pay   (w_payx)
    );

    gsrc_div #(.NW(NS), .QW(NS), .DW(SW), .PW(FW)) u_snap_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_valid),
        .i_num   (w_dny),
        .i_den   (r_grid_step),
        .i_pay   (r_a_py),
        .o_valid (w_divy_valid),
        .o_quo   (w_qy),
        .o_pay   (w_payy)
    );

    // ---------------- stage B: quotient times step ----------------
    logic                 r_b_valid;
    logic [BW-1:0]        r_b_prodx, r_b_prody;
    logic signed [FW-1:0] r_b_px, r_b_py, r_b_ax, r_b_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= w_divx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_prodx <= BW'(w_qx) * BW'(r_grid_step);
            r_b_prody <= BW'(w_qy) * BW'(r_grid_step);
            r_b_px    <= w_payx[3*FW-1:2*FW];
            r_b_ax    <= w_payx[2*FW-1:FW];
            r_b_ay    <= w_payx[FW-1:0];
            r_b_py    <= w_payy;
        end
    end

    // ---------------- stage C: apply sign, bypass when not snapping ----------------
    logic                 r_c_valid;
    logic signed [VW-1:0] r_c_vx, r_c_vy;
    logic signed [FW-1:0] r_c_ax, r_c_ay;
    logic [VW-1:0]        w_mx, w_my;
    logic signed [VW-1:0] n_c_vx, n_c_vy;

    assign w_mx = VW'(r_b_prodx) << FRAC_BITS;
    assign w_my = VW'(r_b_prody) << FRAC_BITS;

    always_comb begin
        if (w_snap) begin
            n_c_vx = r_b_px[FW-1] ? -$signed(w_mx) : $signed(w_mx);
            n_c_vy = r_b_py[FW-1] ? -$signed(w_my) : $signed(w_my);
        end else begin
            n_c_vx = VW'(r_b_px);
            n_c_vy = VW'(r_b_py);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_vx <= n_c_vx;
            r_c_vy <= n_c_vy;
            r_c_ax <= r_b_ax;
            r_c_ay <= r_b_ay;
        end
    end

    // ---------------- stage D: differences to anchor ----------------
    logic                 r_d_valid;
    logic signed [VW:0]   r_d_dx, r_d_dy;
    logic signed [VW-1:0] r_d_vx, r_d_vy;
    logic signed [FW-1:0] r_d_ax, r_d_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_dx <= (VW+1)'(r_c_vx) - (VW+1)'(r_c_ax);
            r_d_dy <= (VW+1)'(r_c_vy) - (VW+1)'(r_c_ay);
            r_d_vx <= r_c_vx;
            r_d_vy <= r_c_vy;
            r_d_ax <= r_c_ax;
            r_d_ay <= r_c_ay;
        end
    end

    // ---------------- stage E: magnitudes, signs, length ----------------
    logic                 r_e_valid;
    logic [VW-1:0]        r_e_adx, r_e_ady, r_e_len;
    logic                 r_e_sgx, r_e_sgy;
    logic signed [VW-1:0] r_e_vx, r_e_vy;
    logic signed [FW-1:0] r_e_ax, r_e_ay;
    logic [VW-1:0]        n_e_adx, n_e_ady;
    logic signed [VW:0]   w_ndx, w_ndy;

    assign w_ndx   = -r_d_dx;
    assign w_ndy   = -r_d_dy;
    assign n_e_adx = r_d_dx[VW] ? w_ndx[VW-1:0] : r_d_dx[VW-1:0];
    assign n_e_ady = r_d_dy[VW] ? w_ndy[VW-1:0] : r_d_dy[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_adx <= n_e_adx;
            r_e_ady <= n_e_ady;
            r_e_len <= (n_e_adx > n_e_ady) ? n_e_adx : n_e_ady;
            r_e_sgx <= !r_d_dx[VW];
            r_e_sgy <= !r_d_dy[VW];
            r_e_vx  <= r_d_vx;
            r_e_vy  <= r_d_vy;
            r_e_ax  <= r_d_ax;
            r_e_ay  <= r_d_ay;
        end
    end

    // ---------------- stage F: lock products, moved-by-length results ----------------
    logic                 r_f_valid;
    logic [PRW-1:0]       r_f_p1, r_f_p2, r_f_p3, r_f_p4;
    logic [LNW-1:0]       r_f_lenn;
    logic signed [RW-1:0] r_f_bx, r_f_by;
    logic                 r_f_lt, r_f_sgx, r_f_sgy;
    logic signed [VW-1:0] r_f_vx, r_f_vy;
    logic signed [FW-1:0] r_f_ax, r_f_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_p1   <= PRW'(r_e_adx) * PRW'(w_coef_a);
            r_f_p2   <= PRW'(r_e_ady) * PRW'(w_coef_b);
            r_f_p3   <= PRW'(r_e_ady) * PRW'(w_coef_a);
            r_f_p4   <= PRW'(r_e_adx) * PRW'(w_coef_b);
            r_f_lenn <= LNW'(r_e_len) * LNW'(w_n);
            r_f_bx   <= r_e_sgx ? (RW'(r_e_ax) + RW'(r_e_len)) : (RW'(r_e_ax) - RW'(r_e_len));
            r_f_by   <= r_e_sgy ? (RW'(r_e_ay) + RW'(r_e_len)) : (RW'(r_e_ay) - RW'(r_e_len));
            r_f_lt   <= r_e_adx < r_e_ady;
            r_f_sgx  <= r_e_sgx;
            r_f_sgy  <= r_e_sgy;
            r_f_vx   <= r_e_vx;
            r_f_vy   <= r_e_vy;
            r_f_ax   <= r_e_ax;
            r_f_ay   <= r_e_ay;
        end
    end

    // ---------------- stage G: lock decision, scale numerator ----------------
    logic                 r_g_valid;
    logic signed [RW-1:0] r_g_rx, r_g_ry;
    logic                 r_g_scx, r_g_scy, r_g_sg;
    logic signed [FW-1:0] r_g_sca;
    logic [NUMW-1:0]      r_g_num;
    logic                 w_lockx, w_locky;
    logic signed [RW-1:0] n_g_rx, n_g_ry;
    logic                 n_g_scx, n_g_scy, n_g_sg;
    logic signed [FW-1:0] n_g_sca;

    assign w_lockx = w_lock_en && (r_f_p1 < r_f_p2);
    assign w_locky = w_lock_en && (r_f_p3 < r_f_p4);

    always_comb begin
        n_g_rx  = RW'(r_f_vx);
        n_g_ry  = RW'(r_f_vy);
        n_g_scx = 1'b0;
        n_g_scy = 1'b0;
        n_g_sg  = r_f_sgx;
        n_g_sca = r_f_ax;
        priority if (r_ratio_mode == gsrc_pkg::MODE_FREE) begin
            n_g_rx = RW'(r_f_vx);
        end else if (w_lockx) begin
            n_g_rx = RW'(r_f_ax);
        end else if (w_locky) begin
            n_g_ry = RW'(r_f_ay);
        end else if (r_ratio_mode == gsrc_pkg::MODE_1_1) begin
            n_g_rx = r_f_bx;
            n_g_ry = r_f_by;
        end else if (r_f_lt) begin
            // x has the shorter leg: it moves by the scaled length
            n_g_rx  = r_f_bx;
            n_g_ry  = r_f_by;
            n_g_scx = 1'b1;
        end else begin
            n_g_rx  = r_f_bx;
            n_g_ry  = r_f_by;
            n_g_scy = 1'b1;
            n_g_sg  = r_f_sgy;
            n_g_sca = r_f_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_rx  <= n_g_rx;
            r_g_ry  <= n_g_ry;
            r_g_scx <= n_g_scx;
            r_g_scy <= n_g_scy;
            r_g_sg  <= n_g_sg;
            r_g_sca <= n_g_sca;
            r_g_num <= (NUMW'(r_f_lenn) << 1) + NUMW'(w_d);
        end
    end

    // Scaled length: floor((2 len n + d) / 2d), quotient never above len.
    logic           w_sdiv_valid;
    logic [VW-1:0]  w_sq;
    logic [SPW-1:0] w_spay;

    gsrc_div #(.NW(NUMW), .QW(VW), .DW(AW + 1), .PW(SPW)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_valid),
        .i_num   (r_g_num),
        .i_den   ({w_d, 1'b0}),
        .i_pay   ({r_g_rx, r_g_ry, r_g_sca, r_g_scx, r_g_scy, r_g_sg}),
        .o_valid (w_sdiv_valid),
        .o_quo   (w_sq),
        .o_pay   (w_spay)
    );

    // ---------------- stage H: finish scaled axis, saturate ----------------
    logic signed [RW-1:0] w_h_rx, w_h_ry, w_h_scaled, w_h_x, w_h_y;
    logic signed [FW-1:0] w_h_sca;
    logic                 w_h_scx, w_h_scy, w_h_sg;

    assign w_h_rx     = w_spay[SPW-1:SPW-RW];
    assign w_h_ry     = w_spay[SPW-RW-1:SPW-2*RW];
    assign w_h_sca    = w_spay[FW+2:3];
    assign w_h_scx    = w_spay[2];
    assign w_h_scy    = w_spay[1];
    assign w_h_sg     = w_spay[0];
    assign w_h_scaled = w_h_sg ? (RW'(w_h_sca) + RW'(w_sq)) : (RW'(w_h_sca) - RW'(w_sq));
    assign w_h_x      = w_h_scx ? w_h_scaled : w_h_rx;
    assign w_h_y      = w_h_scy ? w_h_scaled : w_h_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_en) begin
            r_h_valid <= w_sdiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_x <= gsrc_pkg::f_sat(w_h_x);
            o_out_y <= gsrc_pkg::f_sat(w_h_y);
        end
    end

    assign o_valid = r_h_valid;

    // ---------------- checks ----------------
    `GSRC_ASSERT(a_snap_lanes_sync, i_clk, i_rst_n, w_divx_valid == w_divy_valid, "snap lanes out of step")
    `GSRC_ASSERT(a_one_axis_scaled, i_clk, i_rst_n, !(r_g_valid && r_g_scx && r_g_scy), "both axes scaled")
    `GSRC_ASSERT(a_free_not_scaled, i_clk, i_rst_n, (r_g_valid && r_ratio_mode == gsrc_pkg::MODE_FREE) |-> !(r_g_scx || r_g_scy), "free mode scaled an axis")
    `GSRC_ASSERT_NEXT(a_stall_freezes_pipe, i_clk, i_rst_n, !w_en, $stable(r_e_valid) && $stable(r_g_valid) && o_valid, "pipe moved while stalled")

endmodule
`default_nettype wire

// File: sim/tb_grid_snap_ratio_constrain.sv
// Self-checking testbench for the grid snap and ratio constraint block.
`timescale 1ns / 100ps
module tb_grid_snap_ratio_constrain;

    localparam int FW = gsrc_pkg::C_FW;
    localparam int IDX_W = gsrc_pkg::C_IDX_W;
    localparam int CFG_W = gsrc_pkg::C_CFG_W;
    localparam int FRAC_BITS = gsrc_pkg::C_FRAC_BITS;
    localparam int PIPE_LAT = 100;
    localparam int PHASES = 16;
    localparam int PHASE_ITEMS = 116;
    localparam logic [IDX_W-1:0] CFG_IDX_BAD = 3'd7;
    localparam int FMAX = 8388607;
    localparam int FMIN = -8388608;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [FW-1:0] i_point_x = '0;
    logic signed [FW-1:0] i_point_y = '0;
    logic signed [FW-1:0] i_anchor_x = '0;
    logic signed [FW-1:0] i_anchor_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [FW-1:0] o_out_x;
    logic signed [FW-1:0] o_out_y;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    grid_snap_ratio_constrain DUT (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("grid_snap_ratio_constrain regression: fail");
        $finish;
    end

    // Shadow copy of the register file
    bit              cfg_snap;
    int              cfg_step;
    gsrc_pkg::t_mode cfg_mode;
    int              cfg_low;
    int              cfg_high;

    int exp_x_q[$];
    int exp_y_q[$];
    int err_cnt = 0;
    int burst_left = 0;

    typedef struct {
        bit              snap;
        int              step;
        gsrc_pkg::t_mode mode;
        int              low;
        int              high;
        int              px, py, ax, ay;
        bit              typed;
        int              ex, ey;
    } t_dir_row;

    t_dir_row dir_tab[16];

    function automatic longint snap_coord(input longint p);
        longint s, q;
        if (!cfg_snap || cfg_step == 0) return p;
        s = longint'(cfg_step) << FRAC_BITS;
        q = (2 * (p < 0 ? -p : p) + s) / (2 * s);
        return p < 0 ? -q * s : q * s;
    endfunction

    function automatic int clamp24(input longint v);
        if (v > FMAX) return FMAX;
        if (v < FMIN) return FMIN;
        return int'(v);
    endfunction

    function automatic void constrain_point(input int px, py, ax, ay, output int ox, oy);
        longint vx, vy, dx, dy, adx, ady, len, sgx, sgy, n, d, sc, thr;
        bit lock_x, lock_y;
        vx = snap_coord(px);
        vy = snap_coord(py);
        dx = vx - ax;
        dy = vy - ay;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        len = adx > ady ? adx : ady;
        sgx = dx >= 0 ? 1 : -1;
        sgy = dy >= 0 ? 1 : -1;
        n = 1; d = 1; thr = 2;
        case (cfg_mode)
            gsrc_pkg::MODE_2_1: begin d = 2; thr = 4;  end
            gsrc_pkg::MODE_4_1: begin d = 4; thr = 8;  end
            gsrc_pkg::MODE_8_1: begin d = 8; thr = 16; end
            gsrc_pkg::MODE_5_4: begin n = 4; d = 5; thr = 3; end
            gsrc_pkg::MODE_7_4: begin n = 4; d = 7; thr = 3; end
            gsrc_pkg::MODE_USER: begin
                n = cfg_low < 1 ? 1 : cfg_low;
                d = cfg_high < n ? n : cfg_high;
            end
            default: ;
        endcase
        if (cfg_mode == gsrc_pkg::MODE_USER) begin
            lock_x = (10 * n > d) && (10 * d * adx < 3 * n * ady);
            lock_y = (10 * n > d) && (10 * d * ady < 3 * n * adx);
        end else begin
            lock_x = adx * thr < ady;
            lock_y = ady * thr < adx;
        end
        sc = (2 * len * n + d) / (2 * d);
        if (cfg_mode != gsrc_pkg::MODE_FREE) begin
            if (lock_x) begin
                vx = ax;
            end else if (lock_y) begin
                vy = ay;
            end else if (cfg_mode == gsrc_pkg::MODE_1_1) begin
                vx = ax + sgx * len;
                vy = ay + sgy * len;
            end else if (adx < ady) begin
                vx = ax + sgx * sc;
                vy = ay + sgy * len;
            end else begin
                vx = ax + sgx * len;
                vy = ay + sgy * sc;
            end
        end
        ox = clamp24(vx);
        oy = clamp24(vy);
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (exp_x_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gsrc_pkg::CFG_SNAP_EN:    cfg_snap = data[0];
            gsrc_pkg::CFG_GRID_STEP:  cfg_step = data;
            gsrc_pkg::CFG_RATIO_MODE: cfg_mode = gsrc_pkg::t_mode'(data[2:0]);
            gsrc_pkg::CFG_RATIO_LOW:  cfg_low  = data[7:0];
            gsrc_pkg::CFG_RATIO_HIGH: cfg_high = data[7:0];
            default: ;
        endcase
    endtask

    // Upper data bits are junk the block must mask off
    task automatic load_config(input bit snap, input int step, input gsrc_pkg::t_mode mode,
                               input int low, input int high);
        wait_idle();
        write_reg(gsrc_pkg::CFG_SNAP_EN, {$urandom_range(0, 4095), snap});
        write_reg(gsrc_pkg::CFG_GRID_STEP, step);
        write_reg(gsrc_pkg::CFG_RATIO_MODE, {$urandom_range(0, 1023), mode});
        write_reg(gsrc_pkg::CFG_RATIO_LOW, {$urandom_range(0, 31), low[7:0]});
        write_reg(gsrc_pkg::CFG_RATIO_HIGH, {$urandom_range(0, 31), high[7:0]});
        write_reg(CFG_IDX_BAD, $urandom_range(0, 8191));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input int px, py, ax, ay, input bit typed, input int ex, ey);
        int gap, ox, oy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            gap = 0;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_point_x  <= FW'(px);
        i_point_y  <= FW'(py);
        i_anchor_x <= FW'(ax);
        i_anchor_y <= FW'(ay);
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        if (typed) begin
            ox = ex;
            oy = ey;
        end else begin
            constrain_point(32'(signed'(FW'(px))), 32'(signed'(FW'(py))),
                            32'(signed'(FW'(ax))), 32'(signed'(FW'(ay))), ox, oy);
        end
        exp_x_q.push_back(ox);
        exp_y_q.push_back(oy);
    endtask

    function automatic int srand_mag(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Anchor plus an offset, mostly aimed at the lock thresholds and ratio edges
    task automatic random_point();
        int ax, ay, dx, dy, base, pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_point($urandom, $urandom, $urandom, $urandom, 1'b0, 0, 0);
        end else begin
            case ($urandom_range(0, 3))
                0: begin ax = $urandom; ay = $urandom; end
                1: begin ax = srand_mag(4096); ay = srand_mag(4096); end
                2: begin ax = $urandom_range(0, 1) ? FMAX : FMIN;
                         ay = $urandom_range(0, 1) ? FMAX : FMIN; end
                default: begin ax = srand_mag(1 << 20); ay = srand_mag(1 << 20); end
            endcase
            base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 22)
                 : $urandom_range(0, 3) == 0 ? $urandom_range(0, 300)
                 : $urandom_range(0, 1 << 16);
            case ($urandom_range(0, 3))
                0: dx = srand_mag(1 << 22);
                1: dx = base / int'($urandom_range(1, 17)) + srand_mag(2);
                2: dx = base * 3 / int'($urandom_range(1, 10)) + srand_mag(2);
                default: dx = base;
            endcase
            dy = base;
            if ($urandom_range(0, 1)) begin dx = dy; dy = base / 2 + srand_mag(3); end
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            if ($urandom_range(0, 1)) begin base = dx; dx = dy; dy = base; end
            send_point(ax + dx, ay + dy, ax, ay, 1'b0, 0, 0);
        end
    endtask

    // Receiver stall pattern: none, sparse, mostly stalled or toggling, picked at random
    int stall_cyc = 0;
    int stall_kind = 0;
    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 256 == 0) stall_kind <= $urandom_range(0, 3);
        case (stall_kind)
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            3: i_stall <= stall_cyc[2];
            default: i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        int ex, ey;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_x_q.size() == 0) begin
                $error("unexpected result transaction: out_x %0d out_y %0d", o_out_x, o_out_y);
                err_cnt++;
            end else begin
                ex = exp_x_q.pop_front();
                ey = exp_y_q.pop_front();
                if (int'(o_out_x) != ex) begin
                    $error("out_x expected %0d actual %0d", ex, o_out_x);
                    err_cnt++;
                end
                if (int'(o_out_y) != ey) begin
                    $error("out_y expected %0d actual %0d", ey, o_out_y);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        bit       ph_snap;
        int       ph_step, ph_low, ph_high;
        t_dir_row r;
        cfg_snap = 1'b0;
        cfg_step = gsrc_pkg::C_STEP_RST;
        cfg_mode = gsrc_pkg::MODE_FREE;
        cfg_low  = gsrc_pkg::C_LOW_RST;
        cfg_high = gsrc_pkg::C_HIGH_RST;
        dir_tab = '{
            '{0, 64, gsrc_pkg::MODE_FREE, 1, 3, 0, 0, 0, 0, 1, 0, 0},
            '{0, 64, gsrc_pkg::MODE_FREE, 1, 3, FMAX, FMIN, FMIN, FMAX, 1, FMAX, FMIN},
            '{0, 64, gsrc_pkg::MODE_FREE, 1, 3, FMIN, FMAX, 0, 0, 1, FMIN, FMAX},
            '{0, 64, gsrc_pkg::MODE_FREE, 1, 3, -1, 1, 5, 5, 1, -1, 1},
            // ties round away from zero
            '{1, 64, gsrc_pkg::MODE_FREE, 1, 3, 8192, -8192, 0, 0, 1, 16384, -16384},
            '{1, 0, gsrc_pkg::MODE_FREE, 1, 3, 8192, -8192, 0, 0, 1, 8192, -8192},
            // snapped value beyond the field range saturates
            '{1, 4096, gsrc_pkg::MODE_FREE, 1, 3, FMAX, FMIN, 0, 0, 1, FMAX, FMIN},
            '{1, 4096, gsrc_pkg::MODE_1_1, 1, 3, FMAX, 3000000, FMIN, 0, 0, 0, 0},
            '{1, 8191, gsrc_pkg::MODE_2_1, 1, 3, 7000000, -5000000, 12345, 0, 0, 0, 0},
            '{1, 5000, gsrc_pkg::MODE_4_1, 1, 3, 2000000, 700000, -9000, 100, 0, 0, 0},
            '{0, 64, gsrc_pkg::MODE_8_1, 1, 3, 90000, 7000, 0, 0, 0, 0, 0},
            '{0, 64, gsrc_pkg::MODE_5_4, 1, 3, -50000, 30000, 100, -100, 0, 0, 0},
            '{0, 64, gsrc_pkg::MODE_7_4, 1, 3, 40000, -40001, 0, 0, 0, 0, 0},
            // zero user ratio acts as 1:1
            '{0, 64, gsrc_pkg::MODE_USER, 0, 0, 40000, 1000, 0, 0, 0, 0, 0},
            '{0, 64, gsrc_pkg::MODE_USER, 200, 10, 1000, 40000, 5, 5, 0, 0, 0},
            '{1, 1, gsrc_pkg::MODE_USER, 1, 255, FMIN, FMAX, FMAX, FMIN, 0, 0, 0}
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            r = dir_tab[k];
            if (r.snap != cfg_snap || r.step != cfg_step || r.mode != cfg_mode ||
                r.low != cfg_low || r.high != cfg_high)
                load_config(r.snap, r.step, r.mode, r.low, r.high);
            send_point(r.px, r.py, r.ax, r.ay, r.typed, r.ex, r.ey);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            ph_snap = (ph % 3 != 2);
            case ($urandom_range(0, 5))
                0: ph_step = 0;
                1: ph_step = 1;
                2: ph_step = 4096;
                3: ph_step = 8191;
                4: ph_step = $urandom_range(1, 64);
                default: ph_step = $urandom_range(0, 8191);
            endcase
            ph_low  = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 0 : 255)
                    : $urandom_range(0, 255);
            ph_high = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? 0 : 255)
                    : $urandom_range(0, 255);
            load_config(ph_snap, ph_step, gsrc_pkg::t_mode'(ph % 8), ph_low, ph_high);
            repeat (PHASE_ITEMS) random_point();
        end

        wait_idle();
        repeat (PIPE_LAT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("grid_snap_ratio_constrain regression: pass");
        else
            $display("grid_snap_ratio_constrain regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gsrc_pkg.sv
rtl/gsrc_div.sv
rtl/grid_snap_ratio_constrain.sv
sim/tb_grid_snap_ratio_constrain.sv
